// ----- rtl/ppf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_pkg: shared types and constants of the publish packet framer
// Transaction types, item kinds, phase and sequencer encodings, and widths
// of the length arithmetic.
// ----------------------------------------------------------------------------
package ppf_pkg;

   localparam int PAYLOAD_LEN_BITS = 24;
   localparam int TOPIC_LEN_BITS   = 16;
   localparam int REM_LEN_BITS     =
      ((PAYLOAD_LEN_BITS > TOPIC_LEN_BITS) ? PAYLOAD_LEN_BITS : TOPIC_LEN_BITS + 1) + 1;
   localparam int GROUP_CNT_BITS   = 2;
   localparam int CMD_DEPTH        = 4;
   localparam int CMD_PTR_BITS     = $clog2(CMD_DEPTH);

   localparam logic [7:0] FIXED_HEADER = 8'h30;
   localparam logic [GROUP_CNT_BITS-1:0] GROUP_LAST = '1;

   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_TOPIC   = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] topic_length;
      logic [23:0] payload_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
      logic       bad_item;
   } rsp_type;

   typedef struct packed {
      logic                      is_header;
      logic [REM_LEN_BITS-1:0]   rem_len;
      logic [TOPIC_LEN_BITS-1:0] topic_length;
      logic [7:0]                data_byte;
      logic                      last;
      logic                      bad;
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_TOPIC   = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BK_FETCH    = 2'd0,
      BK_LEN      = 2'd1,
      BK_TOPIC_HI = 2'd2,
      BK_TOPIC_LO = 2'd3
   } back_state_type;

endpackage
`default_nettype wire

// ----- rtl/ppf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_front: item classifier
// Tracks the frame phase and the byte counts, checks each accepted item and
// turns it into one command for the byte sequencer.
// ----------------------------------------------------------------------------
module ppf_front
   import ppf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req_data,
   output cmd_type      cmd_data
);

   phase_type                   phase_ff, phase_in;
   logic [TOPIC_LEN_BITS-1:0]   topic_left_ff, topic_left_in;
   logic [PAYLOAD_LEN_BITS-1:0] payload_left_ff, payload_left_in;
   logic [TOPIC_LEN_BITS-1:0]   tlen;
   logic [PAYLOAD_LEN_BITS-1:0] plen;

   assign tlen = req_data.topic_length;
   assign plen = PAYLOAD_LEN_BITS'(req_data.payload_length);

   always_comb begin
      phase_in              = phase_ff;
      topic_left_in         = topic_left_ff;
      payload_left_in       = payload_left_ff;
      cmd_data.is_header    = 1'b0;
      cmd_data.rem_len      = REM_LEN_BITS'(2) + REM_LEN_BITS'(tlen) + REM_LEN_BITS'(plen);
      cmd_data.topic_length = tlen;
      cmd_data.data_byte    = req_data.data_byte;
      cmd_data.last         = 1'b0;
      cmd_data.bad          = 1'b0;
      if (req_data.kind == KIND_START && phase_ff == PHASE_IDLE) begin
         cmd_data.is_header = 1'b1;
         cmd_data.last      = (tlen == '0) && (plen == '0);
         topic_left_in      = tlen;
         payload_left_in    = plen;
         if (tlen != '0) begin
            phase_in = PHASE_TOPIC;
         end else if (plen != '0) begin
            phase_in = PHASE_PAYLOAD;
         end else begin
            phase_in = PHASE_IDLE;
         end
      end else if (req_data.kind == KIND_TOPIC && phase_ff == PHASE_TOPIC &&
                   topic_left_ff != '0) begin
         topic_left_in = topic_left_ff - TOPIC_LEN_BITS'(1);
         if (topic_left_in == '0) begin
            if (payload_left_ff != '0) begin
               phase_in = PHASE_PAYLOAD;
            end else begin
               phase_in      = PHASE_IDLE;
               cmd_data.last = 1'b1;
            end
         end
      end else if (req_data.kind == KIND_PAYLOAD && phase_ff == PHASE_PAYLOAD &&
                   payload_left_ff != '0) begin
         payload_left_in = payload_left_ff - PAYLOAD_LEN_BITS'(1);
         if (payload_left_in == '0) begin
            phase_in      = PHASE_IDLE;
            cmd_data.last = 1'b1;
         end
      end else begin
         cmd_data.bad       = 1'b1;
         cmd_data.data_byte = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_IDLE;
         topic_left_ff   <= '0;
         payload_left_ff <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         topic_left_ff   <= topic_left_in;
         payload_left_ff <= payload_left_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ppf_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_cmd_fifo: command queue
// Short queue that decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module ppf_cmd_fifo
   import ppf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);

   cmd_type                 entry_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_BITS:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full     = (count_ff == (CMD_PTR_BITS+1)'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (CMD_PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (CMD_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ppf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_back: byte sequencer
// Takes commands from the queue and emits the frame bytes into the result
// register: the fixed header, the varint remaining length and the topic
// length bytes for a start command, one byte for any other command.
// ----------------------------------------------------------------------------
module ppf_back
   import ppf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd_data,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   input  wire logic    rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data
);

   back_state_type            state_ff, state_in;
   logic [REM_LEN_BITS-1:0]   rem_ff, rem_in;
   logic [REM_LEN_BITS-1:0]   rem_shift;
   logic [GROUP_CNT_BITS-1:0] grp_cnt_ff, grp_cnt_in;
   logic [TOPIC_LEN_BITS-1:0] tlen_ff, tlen_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      can_load;
   logic                      rsp_load;

   assign can_load  = !rsp_valid_ff || rsp_pop;
   assign rem_shift = rem_ff >> 7;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_FETCH: begin
            if (can_load && !cmd_empty && cmd_data.is_header) begin
               state_in = BK_LEN;
            end
         end
         BK_LEN: begin
            if (can_load && (rem_shift == '0 || grp_cnt_ff == GROUP_LAST)) begin
               state_in = BK_TOPIC_HI;
            end
         end
         BK_TOPIC_HI: begin
            if (can_load) begin
               state_in = BK_TOPIC_LO;
            end
         end
         BK_TOPIC_LO: begin
            if (can_load) begin
               state_in = BK_FETCH;
            end
         end
         default: begin
            state_in = BK_FETCH;
         end
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      rsp_load   = 1'b0;
      rsp_in     = rsp_ff;
      rem_in     = rem_ff;
      grp_cnt_in = grp_cnt_ff;
      tlen_in    = tlen_ff;
      last_in    = last_ff;
      case (state_ff)
         BK_FETCH: begin
            if (can_load && !cmd_empty) begin
               cmd_pop  = 1'b1;
               rsp_load = 1'b1;
               if (cmd_data.is_header) begin
                  rsp_in     = '{out_byte: FIXED_HEADER, frame_last: 1'b0, bad_item: 1'b0};
                  rem_in     = cmd_data.rem_len;
                  grp_cnt_in = '0;
                  tlen_in    = cmd_data.topic_length;
                  last_in    = cmd_data.last;
               end else begin
                  rsp_in = '{out_byte: cmd_data.data_byte, frame_last: cmd_data.last,
                             bad_item: cmd_data.bad};
               end
            end
         end
         BK_LEN: begin
            if (can_load) begin
               rsp_load   = 1'b1;
               rsp_in     = '{out_byte: {rem_shift != '0, rem_ff[6:0]}, frame_last: 1'b0,
                              bad_item: 1'b0};
               rem_in     = rem_shift;
               grp_cnt_in = grp_cnt_ff + GROUP_CNT_BITS'(1);
            end
         end
         BK_TOPIC_HI: begin
            if (can_load) begin
               rsp_load = 1'b1;
               rsp_in   = '{out_byte: tlen_ff[15:8], frame_last: 1'b0, bad_item: 1'b0};
            end
         end
         BK_TOPIC_LO: begin
            if (can_load) begin
               rsp_load = 1'b1;
               rsp_in   = '{out_byte: tlen_ff[7:0], frame_last: last_ff, bad_item: 1'b0};
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_FETCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      rem_ff     <= rem_in;
      grp_cnt_ff <= grp_cnt_in;
      tlen_ff    <= tlen_in;
      last_ff    <= last_in;
   end

endmodule
`default_nettype wire

// ----- rtl/publish_packet_framer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// publish_packet_framer_core: PUBLISH QoS 0 frame encoder
// Turns start, topic byte and payload byte transactions into the byte
// stream of a publish frame; unexpected transactions give one error result.
//
//   Channel   Ports                           Direction
//   request   req_push, req_full, req_data    in  (req_type)
//   response  rsp_empty, rsp_pop, rsp_data    out (rsp_type)
//
// A result passes through the command queue and then the result register. A topic
// or payload byte, or a rejected transaction, gives one result byte from the byte
// sequencer; a start gives 4 to 7 header bytes, one after another.
// A four-entry command queue lets requests keep coming while the header drains.
// Reset is synchronous and empties both the queue and the result register.
// A held result stalls the sequencer; once the queue is full, req_full rises.
// ----------------------------------------------------------------------------
module publish_packet_framer_core
   import ppf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   logic    accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   ppf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_data (push_cmd)
   );

   ppf_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (pop_cmd),
      .empty     (cmd_empty)
   );

   ppf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (pop_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.bad_item) |-> (rsp_data.out_byte == 8'h00 &&
                                              !rsp_data.frame_last))
      else $error("error result carries a data byte or a frame end");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(cmd_full && cmd_empty))
      else $error("command queue is both full and empty");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("sequencer took a command from an empty queue");

endmodule
`default_nettype wire
